@@ sv/epm_pkg.sv @@
// shared types and constants of the encoder period rpm meter
`default_nettype none

package epm_pkg;

   localparam int HISTORY_DEPTH = 14;
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam int TIME_W = 32;
   localparam int WINDOW_W = 32;
   localparam int TICKS_W = 16;
   localparam int RPM_W = 16;

   localparam int SUM_W = TIME_W + CNT_W;
   localparam int SUM_LO_W = (SUM_W + 1) / 2;
   localparam int SUM_HI_W = SUM_W - SUM_LO_W;
   localparam int PLO_W = TICKS_W + SUM_LO_W;
   localparam int PHI_W = TICKS_W + SUM_HI_W;
   localparam int DEN_W = TICKS_W + SUM_W;

   localparam int US_PER_MINUTE = 60000000;
   localparam int MINUTE_W = 26;
   localparam int NUM_W = CNT_W + MINUTE_W;
   localparam int DSH_W = NUM_W + RPM_W - 1;
   localparam int STEP_W = $clog2(RPM_W);

   localparam logic [RPM_W-1:0] RPM_MAX = '1;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd300000;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd20;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_US     = 1'b0,
      CSR_TICKS_PER_REV = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_EDGE  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef struct packed {
      command_type       command;
      logic [TIME_W-1:0] time_us;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } front_out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_MUL,
      ST_SUM,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

@@ sv/epm_front.sv @@
// front end: accepts and classifies items into a short queue for the back end
`default_nettype none

module epm_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   input  wire logic                        req_command,
   input  wire logic [epm_pkg::TIME_W-1:0]  req_time_us,
   output logic                             req_full,
   output epm_pkg::front_out_type           front_out,
   input  wire logic                        item_take
);

   epm_pkg::item_type                 queue_ff [epm_pkg::QUEUE_DEPTH];
   logic [epm_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [epm_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [epm_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              push_ok;
   logic                              pop_ok;
   epm_pkg::item_type                 new_item;

   assign req_full = (count_ff == epm_pkg::QCNT_W'(epm_pkg::QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = item_take && (count_ff != '0);

   assign front_out.valid = (count_ff != '0);
   assign front_out.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.command = req_command ? epm_pkg::CMD_QUERY : epm_pkg::CMD_EDGE;
      new_item.time_us = req_time_us;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == epm_pkg::QPTR_W'(epm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == epm_pkg::QPTR_W'(epm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

@@ sv/epm_back.sv @@
// back end: edge history, windowed walk, denominator build and serial divide
`default_nettype none

module epm_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire epm_pkg::front_out_type         front_out,
   output logic                                item_take,
   input  wire logic                           csr_write,
   input  wire logic [epm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [epm_pkg::WINDOW_W-1:0]   csr_data,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [epm_pkg::RPM_W-1:0]           rsp_rpm
);

   localparam int DEPTH = epm_pkg::HISTORY_DEPTH;

   logic [epm_pkg::TIME_W-1:0]   interval_ff [DEPTH];
   logic [epm_pkg::TIME_W-1:0]   stamp_ff    [DEPTH];
   logic                         shift_en;

   epm_pkg::back_state_type      state_ff, state_in;
   logic [epm_pkg::TIME_W-1:0]   last_edge_ff, last_edge_in;
   logic [epm_pkg::CNT_W-1:0]    valid_count_ff, valid_count_in;
   logic [epm_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [epm_pkg::TICKS_W-1:0]  ticks_ff, ticks_in;
   logic [epm_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [epm_pkg::CNT_W-1:0]    walk_ff, walk_in;
   logic [epm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [epm_pkg::PLO_W-1:0]    plo_ff, plo_in;
   logic [epm_pkg::PHI_W-1:0]    phi_ff, phi_in;
   logic [epm_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [epm_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [epm_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic [epm_pkg::DSH_W-1:0]    dsh_ff, dsh_in;
   logic [epm_pkg::RPM_W-1:0]    quo_ff, quo_in;
   logic [epm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [epm_pkg::RPM_W-1:0]    result_ff, result_in;
   logic                         out_valid_ff, out_valid_in;
   logic [epm_pkg::RPM_W-1:0]    out_rpm_ff, out_rpm_in;

   logic [epm_pkg::IDX_W-1:0]    rd_idx;
   logic [epm_pkg::TIME_W-1:0]   age;
   logic                         take_entry;
   logic                         div_ge;
   logic                         sat_ge;

   assign rsp_empty = !out_valid_ff;
   assign rsp_rpm   = out_rpm_ff;

   assign rd_idx = (walk_ff < epm_pkg::CNT_W'(DEPTH)) ? walk_ff[epm_pkg::IDX_W-1:0] : '0;
   assign age    = now_ff - stamp_ff[rd_idx];
   assign take_entry = (walk_ff < valid_count_ff) && (age < window_ff);
   assign div_ge = ({(epm_pkg::RPM_W-1)'(0), rem_ff} >= dsh_ff);
   // quotient of 65536 or more means saturation
   assign sat_ge = ({epm_pkg::RPM_W'(0), num_ff} >=
                    {den_ff[epm_pkg::NUM_W-1:0], epm_pkg::RPM_W'(0)});

   always_comb begin
      state_in       = state_ff;
      last_edge_in   = last_edge_ff;
      valid_count_in = valid_count_ff;
      window_in      = window_ff;
      ticks_in       = ticks_ff;
      now_in         = now_ff;
      walk_in        = walk_ff;
      sum_in         = sum_ff;
      plo_in         = plo_ff;
      phi_in         = phi_ff;
      den_in         = den_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      result_in      = result_ff;
      out_valid_in   = out_valid_ff;
      out_rpm_in     = out_rpm_ff;
      item_take      = 1'b0;
      shift_en       = 1'b0;

      if (csr_write) begin
         case (csr_index)
            epm_pkg::CSR_WINDOW_US:     window_in = csr_data;
            epm_pkg::CSR_TICKS_PER_REV: ticks_in  = csr_data[epm_pkg::TICKS_W-1:0];
            default: ;
         endcase
      end

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         epm_pkg::ST_IDLE: begin
            if (front_out.valid) begin
               item_take = 1'b1;
               if (front_out.item.command == epm_pkg::CMD_EDGE) begin
                  shift_en     = 1'b1;
                  last_edge_in = front_out.item.time_us;
                  if (valid_count_ff < epm_pkg::CNT_W'(DEPTH)) begin
                     valid_count_in = valid_count_ff + 1'b1;
                  end
               end else begin
                  now_in   = front_out.item.time_us;
                  walk_in  = '0;
                  sum_in   = '0;
                  state_in = epm_pkg::ST_WALK;
               end
            end
         end
         epm_pkg::ST_WALK: begin
            if (take_entry) begin
               sum_in  = sum_ff + epm_pkg::SUM_W'(interval_ff[rd_idx]);
               walk_in = walk_ff + 1'b1;
            end else begin
               state_in = epm_pkg::ST_MUL;
            end
         end
         epm_pkg::ST_MUL: begin
            // ticks times sum as two narrow partial products
            plo_in   = ticks_ff * sum_ff[epm_pkg::SUM_LO_W-1:0];
            phi_in   = ticks_ff * sum_ff[epm_pkg::SUM_W-1:epm_pkg::SUM_LO_W];
            state_in = epm_pkg::ST_SUM;
         end
         epm_pkg::ST_SUM: begin
            den_in   = epm_pkg::DEN_W'(plo_ff) +
                       (epm_pkg::DEN_W'(phi_ff) << epm_pkg::SUM_LO_W);
            num_in   = epm_pkg::NUM_W'(walk_ff) *
                       epm_pkg::NUM_W'(epm_pkg::US_PER_MINUTE);
            state_in = epm_pkg::ST_PREP;
         end
         epm_pkg::ST_PREP: begin
            if (walk_ff == '0) begin
               result_in = '0;
               state_in  = epm_pkg::ST_DONE;
            end else if (den_ff == '0) begin
               result_in = epm_pkg::RPM_MAX;
               state_in  = epm_pkg::ST_DONE;
            end else if (den_ff[epm_pkg::DEN_W-1:epm_pkg::NUM_W] != '0) begin
               // denominator beyond any numerator
               result_in = '0;
               state_in  = epm_pkg::ST_DONE;
            end else if (sat_ge) begin
               result_in = epm_pkg::RPM_MAX;
               state_in  = epm_pkg::ST_DONE;
            end else begin
               rem_in   = num_ff;
               dsh_in   = {den_ff[epm_pkg::NUM_W-1:0], (epm_pkg::RPM_W-1)'(0)};
               quo_in   = '0;
               step_in  = epm_pkg::STEP_W'(epm_pkg::RPM_W - 1);
               state_in = epm_pkg::ST_DIV;
            end
         end
         epm_pkg::ST_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - dsh_ff[epm_pkg::NUM_W-1:0];
            end
            quo_in = {quo_ff[epm_pkg::RPM_W-2:0], div_ge};
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               result_in = quo_in;
               state_in  = epm_pkg::ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         epm_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_rpm_in   = result_ff;
               state_in     = epm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = epm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= epm_pkg::ST_IDLE;
         last_edge_ff   <= '0;
         valid_count_ff <= '0;
         window_ff      <= epm_pkg::WINDOW_RESET;
         ticks_ff       <= epm_pkg::TICKS_RESET;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_edge_ff   <= last_edge_in;
         valid_count_ff <= valid_count_in;
         window_ff      <= window_in;
         ticks_ff       <= ticks_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      walk_ff    <= walk_in;
      sum_ff     <= sum_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      result_ff  <= result_in;
      out_rpm_ff <= out_rpm_in;
   end

   // newest-first history, oldest entry drops off the end
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int k = DEPTH - 1; k > 0; k--) begin
            interval_ff[k] <= interval_ff[k-1];
            stamp_ff[k]    <= stamp_ff[k-1];
         end
         interval_ff[0] <= front_out.item.time_us - last_edge_ff;
         stamp_ff[0]    <= front_out.item.time_us;
      end
   end

endmodule

`default_nettype wire

@@ sv/encoder_period_rpm_meter_top.sv @@
// Encoder period rpm meter, top level.
//
// Input channel (req_push/req_full): each item is an encoder edge
// (req_command 0) or a speed query (req_command 1), stamped with
// req_time_us. A transfer happens when req_push is high and req_full low.
// Items enter a two-entry queue, so the front keeps taking items while the
// back end works or a result waits, until the queue is full.
// Result channel (rsp_empty/rsp_pop): one rsp_rpm per query, none per edge,
// in query order. A stalled result holds on rsp_rpm until popped; while it
// waits the back end finishes the next query and then holds it.
// Config channel (csr_valid/csr_ready): csr_ready is always high; index 0 is
// window_us, index 1 is ticks_per_rev. Write only while the block is idle.
// Flow: an edge enters the history from the back end's idle state. From its
// transfer in, a query passes the input queue, the history walk (one entry
// per cycle), the denominator states ST_MUL, ST_SUM and ST_PREP, the
// bit-serial divider when it runs, and ST_DONE, which loads the result
// register once no earlier result waits or it is being popped.
// Reset clears the queue, the history count, the pending result and
// returns both registers to their reset values; no clearing pass is needed.
`default_nettype none

module encoder_period_rpm_meter_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_command,
   input  wire logic [epm_pkg::TIME_W-1:0]     req_time_us,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [epm_pkg::RPM_W-1:0]           rsp_rpm,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [epm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [epm_pkg::WINDOW_W-1:0]   csr_data
);

   epm_pkg::front_out_type front_out;
   logic                   item_take;
   logic                   csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   epm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_command (req_command),
      .req_time_us (req_time_us),
      .req_full    (req_full),
      .front_out   (front_out),
      .item_take   (item_take)
   );

   epm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .front_out (front_out),
      .item_take (item_take),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_rpm   (rsp_rpm)
   );

endmodule

`default_nettype wire

@@ sv/epm_checker.sv @@
// port-level checks of the rpm meter and their binding to the top level
`default_nettype none

module epm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_push,
   input wire logic                        req_full,
   input wire logic                        rsp_empty,
   input wire logic                        rsp_pop,
   input wire logic [epm_pkg::RPM_W-1:0]   rsp_rpm
);

   // reset leaves no result and room in the queue
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not clean after reset");

   // a query cannot give a result this soon after reset, and one transfer cannot fill the queue
   a_reset_settle: assert property (@(posedge clock)
      reset |=> ##1 (rsp_empty && !req_full))
      else $error("result or full too soon after reset");

   // a waiting result stays and holds its value until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_rpm)))
      else $error("stalled result changed");

   // the queue can only become full after a transfer in
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without a transfer in");

endmodule

bind encoder_period_rpm_meter_top epm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_rpm   (rsp_rpm)
);

`default_nettype wire
